// File: src/opa_pkg.sv
// Shared types and constants for the object pool allocator.
// No dependencies; every other file but src/opa_checker.sv imports this package.
`timescale 1ns / 1ps

package opa_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int ID_W       = 4;
  localparam int CNT_W      = 5;
  localparam int PTR_W      = $clog2(POOL_DEPTH);

  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // register index of max_objects
  localparam logic [APB_AW-3:0] REG_MAX_OBJECTS = '0;
  localparam logic [CNT_W-1:0]  MAX_OBJECTS_RST = CNT_W'(POOL_DEPTH);

  typedef enum logic {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  // classified word handed from front to back
  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic             accepted;
    logic [ID_W-1:0]  granted_id;
    logic             newly_created;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] busy_count;
    logic [CNT_W-1:0] created_count;
  } result_t;

endpackage

// File: src/opa_front.sv
// Front end: takes input words, decodes the operation and registers it.
// Depends on opa_pkg.
`timescale 1ns / 1ps

module opa_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic [opa_pkg::ID_W-1:0]  object_id_i,
  output logic                      cmd_valid_o,
  output opa_pkg::cmd_t             cmd_o,
  input  logic                      cmd_ready_i
);
  import opa_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign in_ready_o = !valid_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (cmd_valid_o && cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      if (kind_i) begin
        cmd_d.kind = KIND_RELEASE;
        cmd_d.id   = object_id_i;
      end else begin
        // id means nothing for an acquire
        cmd_d.kind = KIND_ACQUIRE;
        cmd_d.id   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// File: src/opa_cmd_fifo.sv
// Two-entry queue between front and back so each side stalls on its own.
// Depends on opa_pkg.
`timescale 1ns / 1ps

module opa_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  opa_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output opa_pkg::cmd_t pop_cmd_o
);
  import opa_pkg::*;

  localparam int Depth = 2;

  cmd_t       slot_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'(Depth));
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: src/opa_back.sv
// Back end: free queue, in-use marks, counters and the result register.
// Depends on opa_pkg.
`timescale 1ns / 1ps

module opa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [opa_pkg::CNT_W-1:0]  max_objects_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  opa_pkg::cmd_t              cmd_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output opa_pkg::result_t           res_o
);
  import opa_pkg::*;

  logic [ID_W-1:0]       free_q [POOL_DEPTH];
  logic [PTR_W-1:0]      head_q, head_d;
  logic [PTR_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [CNT_W-1:0]      minted_q, minted_d;
  logic [CNT_W-1:0]      busy_q, busy_d;
  logic [POOL_DEPTH-1:0] marks_q, marks_d;
  logic                  res_valid_q, res_valid_d;
  result_t               res_q, res_d;

  logic             take;
  logic [CNT_W-1:0] limit;
  logic [ID_W-1:0]  head_id;
  logic             push;

  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign head_id     = free_q[head_q];
  assign limit       = (max_objects_i > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH)
                                                             : max_objects_i;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    minted_d    = minted_q;
    busy_d      = busy_q;
    marks_d     = marks_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    push        = 1'b0;

    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end

    if (take) begin
      res_valid_d         = 1'b1;
      res_d.accepted      = 1'b0;
      res_d.granted_id    = '0;
      res_d.newly_created = 1'b0;
      case (cmd_i.kind)
        KIND_ACQUIRE: begin
          if (fill_q != '0) begin
            // reuse the oldest freed id
            res_d.accepted   = 1'b1;
            res_d.granted_id = head_id;
            marks_d[head_id] = 1'b1;
            head_d = (head_q == PTR_W'(POOL_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
            fill_d = fill_q - CNT_W'(1);
            busy_d = busy_q + CNT_W'(1);
          end else if (minted_q < limit) begin
            res_d.accepted      = 1'b1;
            res_d.granted_id    = minted_q[ID_W-1:0];
            res_d.newly_created = 1'b1;
            marks_d[minted_q[ID_W-1:0]] = 1'b1;
            minted_d = minted_q + CNT_W'(1);
            busy_d   = busy_q + CNT_W'(1);
          end
        end
        KIND_RELEASE: begin
          // a release of an id not in use is refused and dropped
          if (marks_q[cmd_i.id] && (fill_q < CNT_W'(POOL_DEPTH))) begin
            res_d.accepted   = 1'b1;
            marks_d[cmd_i.id] = 1'b0;
            push   = 1'b1;
            tail_d = (tail_q == PTR_W'(POOL_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
            fill_d = fill_q + CNT_W'(1);
            busy_d = busy_q - CNT_W'(1);
          end
        end
        default: begin
          res_d.accepted = 1'b0;
        end
      endcase
      res_d.free_count    = fill_d;
      res_d.busy_count    = busy_d;
      res_d.created_count = minted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      minted_q    <= '0;
      busy_q      <= '0;
      marks_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      minted_q    <= minted_d;
      busy_q      <= busy_d;
      marks_q     <= marks_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (push) begin
      free_q[tail_q] <= cmd_i.id;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: src/object_pool_allocator_unit.sv
// Object pool allocator: hands out and takes back object ids from a pool.
// A word is registered in the front end, queued in the command FIFO and
// its result registered in the back end. Throughput: one word per cycle
// without a stall; the free queue is read and written once per cycle there.
// Reset: asynchronous active low; pool empty, nothing minted, limit 16.
// Depends on opa_pkg, opa_front, opa_cmd_fifo, opa_back.
`timescale 1ns / 1ps

module object_pool_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [opa_pkg::APB_AW-1:0]  paddr,
  input  logic [opa_pkg::APB_DW-1:0]  pwdata,
  output logic [opa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [opa_pkg::ID_W-1:0]    object_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic [opa_pkg::ID_W-1:0]    granted_id_o,
  output logic                        newly_created_o,
  output logic [opa_pkg::CNT_W-1:0]   free_count_o,
  output logic [opa_pkg::CNT_W-1:0]   busy_count_o,
  output logic [opa_pkg::CNT_W-1:0]   created_count_o
);
  import opa_pkg::*;

  logic [CNT_W-1:0] max_objects_q;
  logic             reg_hit;
  logic             front_valid, front_ready;
  cmd_t             front_cmd;
  logic             fifo_valid, fifo_ready;
  cmd_t             fifo_cmd;
  result_t          res;

  // config register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_MAX_OBJECTS);
  assign prdata  = reg_hit ? APB_DW'(max_objects_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_objects_q <= MAX_OBJECTS_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      max_objects_q <= pwdata[CNT_W-1:0];
    end
  end

  opa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .object_id_i (object_id_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  opa_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (fifo_valid),
    .pop_ready_i  (fifo_ready),
    .pop_cmd_o    (fifo_cmd)
  );

  opa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_objects_i (max_objects_q),
    .cmd_valid_i   (fifo_valid),
    .cmd_ready_o   (fifo_ready),
    .cmd_i         (fifo_cmd),
    .res_valid_o   (out_valid_o),
    .res_ready_i   (out_ready_i),
    .res_o         (res)
  );

  assign accepted_o      = res.accepted;
  assign granted_id_o    = res.granted_id;
  assign newly_created_o = res.newly_created;
  assign free_count_o    = res.free_count;
  assign busy_count_o    = res.busy_count;
  assign created_count_o = res.created_count;

endmodule

// File: src/opa_checker.sv
// Port-level checks for the object pool allocator, bound to the top level.
// Depends on object_pool_allocator_unit port names only.
`timescale 1ns / 1ps

module opa_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       accepted_o,
  input logic [3:0] granted_id_o,
  input logic       newly_created_o,
  input logic [4:0] free_count_o,
  input logic [4:0] busy_count_o,
  input logic [4:0] created_count_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_id_o)
      && $stable(accepted_o) && $stable(free_count_o) && $stable(busy_count_o))
    else $error("result word changed while stalled");

  // queued plus in use never exceeds minted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, free_count_o} + {1'b0, busy_count_o})
      <= {1'b0, created_count_o})
    else $error("free plus busy exceeds created");

  // a fresh id is the last one minted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && newly_created_o |-> accepted_o
      && ({1'b0, granted_id_o} == created_count_o - 5'd1))
    else $error("minted id does not match created count");

  // refused words carry no id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> (granted_id_o == 4'd0) && !newly_created_o)
    else $error("refused word carries a grant");

endmodule

bind object_pool_allocator_unit opa_port_checks u_port_checks (.*);

// File: test/opa_checker.sv
// Checker for the object pool allocator: watches the config port and both word
// channels, predicts each result from its own pool model and compares.
// Depends on opa_pkg only.
`timescale 1ns / 1ps

module opa_checker
  import opa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              kind_i,
  input  logic [ID_W-1:0]   object_id_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              accepted_i,
  input  logic [ID_W-1:0]   granted_id_i,
  input  logic              newly_created_i,
  input  logic [CNT_W-1:0]  free_count_i,
  input  logic [CNT_W-1:0]  busy_count_i,
  input  logic [CNT_W-1:0]  created_count_i,
  output int unsigned       fail_count_o,
  output int unsigned       due_count_o,
  output int unsigned       checked_count_o
);

  localparam logic [APB_AW-1:0] LIMIT_ADDR = {REG_MAX_OBJECTS, 2'b00};

  // pool model
  logic [CNT_W-1:0]      pool_limit;
  logic [ID_W-1:0]       free_ids[$];
  logic [POOL_DEPTH-1:0] busy_ids;
  int unsigned           minted_ids;

  result_t     due_results[$];
  int unsigned fails;
  int unsigned checked;

  function automatic result_t next_pool_result(kind_e op, logic [ID_W-1:0] id);
    result_t     r;
    int unsigned cap;
    r   = '0;
    // zero allows no minting, anything above the pool is clamped
    cap = (pool_limit > POOL_DEPTH) ? POOL_DEPTH : pool_limit;
    if (op == KIND_ACQUIRE) begin
      if (free_ids.size() > 0) begin
        r.granted_id        = free_ids.pop_front();
        busy_ids[r.granted_id] = 1'b1;
        r.accepted          = 1'b1;
      end else if (minted_ids < cap) begin
        r.granted_id        = ID_W'(minted_ids);
        busy_ids[r.granted_id] = 1'b1;
        minted_ids++;
        r.accepted          = 1'b1;
        r.newly_created     = 1'b1;
      end
    end else if (busy_ids[id] && free_ids.size() < POOL_DEPTH) begin
      busy_ids[id] = 1'b0;
      free_ids     = {free_ids, id};
      r.accepted = 1'b1;
    end
    r.free_count    = CNT_W'(free_ids.size());
    r.busy_count    = CNT_W'($countones(busy_ids));
    r.created_count = CNT_W'(minted_ids);
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("acc=%0d id=%0d new=%0d free=%0d busy=%0d made=%0d",
                     r.accepted, r.granted_id, r.newly_created,
                     r.free_count, r.busy_count, r.created_count);
  endfunction

  task automatic flag(string msg);
    fails++;
    if (fails <= 10) $display("%0t ns  MISMATCH %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      pool_limit = MAX_OBJECTS_RST;
      free_ids.delete();
      busy_ids   = '0;
      minted_ids = 0;
      due_results.delete();
      fails      = 0;
      checked    = 0;
    end else begin
      if (psel && penable && !pwrite && pready && paddr == LIMIT_ADDR &&
          prdata !== APB_DW'(pool_limit))
        flag($sformatf("limit readback: expected %0d, got %0d", pool_limit, prdata));
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        pool_limit = pwdata[CNT_W-1:0];
      if (in_valid_i && in_ready_i) begin
        want        = next_pool_result(kind_e'(kind_i), object_id_i);
        due_results = {due_results, want};
      end
      if (out_valid_i && out_ready_i) begin
        got = '{accepted_i, granted_id_i, newly_created_i,
                free_count_i, busy_count_i, created_count_i};
        checked++;
        if (due_results.size() == 0) begin
          flag({"word with nothing due: ", show(got)});
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            flag({"expected ", show(want), " | got ", show(got)});
        end
      end
    end
    fail_count_o    = fails;
    due_count_o     = due_results.size();
    checked_count_o = checked;
  end

endmodule

// File: test/testbench.sv
// Top of the object pool allocator testbench: clock, reset, stimulus, stalls
// on the result side and the verdict. Depends on opa_pkg, opa_checker and
// the object_pool_allocator_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import opa_pkg::*;

  localparam logic [APB_AW-1:0] LIMIT_ADDR = {REG_MAX_OBJECTS, 2'b00};

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_ready_o;
  logic              kind      = 1'b0;
  logic [ID_W-1:0]   object_id = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic              accepted_o;
  logic [ID_W-1:0]   granted_id_o;
  logic              newly_created_o;
  logic [CNT_W-1:0]  free_count_o;
  logic [CNT_W-1:0]  busy_count_o;
  logic [CNT_W-1:0]  created_count_o;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned checked_count;

  int unsigned burst_left = 0;
  int unsigned gap_max    = 4;
  int unsigned n_acquire  = 0;
  int unsigned n_release  = 0;
  int unsigned n_limits   = 0;

  always #10 clk_i = ~clk_i;

  object_pool_allocator_unit i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i      (in_valid),
    .in_ready_o,
    .kind_i          (kind),
    .object_id_i     (object_id),
    .out_valid_o,
    .out_ready_i     (out_ready),
    .accepted_o, .granted_id_o, .newly_created_o,
    .free_count_o, .busy_count_o, .created_count_o
  );

  opa_checker i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready_o),
    .kind_i          (kind),
    .object_id_i     (object_id),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready),
    .accepted_i      (accepted_o),
    .granted_id_i    (granted_id_o),
    .newly_created_i (newly_created_o),
    .free_count_i    (free_count_o),
    .busy_count_i    (busy_count_o),
    .created_count_i (created_count_o),
    .fail_count_o    (fail_count),
    .due_count_o     (due_count),
    .checked_count_o (checked_count)
  );

  // result side: the stall style is picked at random, from always ready to mostly stalled
  int unsigned stall_style = 0;
  int unsigned style_left  = 0;

  always @(negedge clk_i) begin
    if (style_left == 0) begin
      style_left  = $urandom_range(30, 200);
      stall_style = $urandom_range(0, 3);
    end else begin
      style_left--;
    end
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      2:       out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_word(kind_e op, logic [ID_W-1:0] id);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid  <= 1'b1;
    kind      <= op;
    object_id <= id;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == KIND_ACQUIRE) n_acquire++;
    else                    n_release++;
  endtask

  // hold off until every result is back, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_cycle(logic wr, logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LIMIT_ADDR;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(logic [CNT_W-1:0] value);
    drain();
    apb_cycle(1'b1, APB_DW'(value));
    apb_cycle(1'b0, '0);
    n_limits++;
  endtask

  task automatic random_phase(int unsigned words, int unsigned acquire_pct);
    repeat (words) begin
      if ($urandom_range(0, 99) < acquire_pct) send_word(KIND_ACQUIRE, ID_W'($urandom));
      else                                     send_word(KIND_RELEASE, ID_W'($urandom));
      if ($urandom_range(0, 299) == 0) drain();
    end
  endtask

  initial begin
    logic [CNT_W-1:0] limits[8];
    int unsigned      pcts[4];
    limits = '{5'd9, 5'd31, 5'd0, 5'd16, 5'd12, 5'd1, 5'd16, 5'd5};
    pcts   = '{25, 50, 75, 90};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // limit zero: nothing can be minted, nothing is in use
    set_limit(5'd0);
    send_word(KIND_ACQUIRE, 4'd15);
    send_word(KIND_RELEASE, 4'd0);
    send_word(KIND_RELEASE, 4'd15);

    // single object: exhaust, double release, reuse from the queue
    set_limit(5'd1);
    send_word(KIND_ACQUIRE, 4'd0);
    send_word(KIND_ACQUIRE, 4'd0);
    send_word(KIND_RELEASE, 4'd0);
    send_word(KIND_RELEASE, 4'd0);
    send_word(KIND_ACQUIRE, 4'd15);

    // limit above the pool gets clamped
    set_limit(5'd31);
    repeat (5) send_word(KIND_ACQUIRE, 4'd0);
    send_word(KIND_RELEASE, 4'd3);
    send_word(KIND_RELEASE, 4'd1);
    send_word(KIND_ACQUIRE, 4'd0);
    send_word(KIND_RELEASE, 4'd15);

    // limit dropped below what is minted: queue still serves, minting stops
    set_limit(5'd2);
    send_word(KIND_ACQUIRE, 4'd0);
    send_word(KIND_ACQUIRE, 4'd0);

    foreach (limits[i]) begin
      set_limit(limits[i]);
      gap_max = (i % 3 == 0) ? 0 : $urandom_range(1, 8);
      random_phase(185, pcts[$urandom_range(0, 3)]);
    end

    drain();
    $display("covered %0d acquires and %0d releases over %0d limit settings;",
             n_acquire, n_release, n_limits);
    $display("%0d result words compared, %0d failures", checked_count, fail_count);
    if (fail_count == 0 && due_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", due_count);
    $display("testbench failed");
    $finish;
  end

endmodule
